// ----- rtl/cht_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the chained hash table.
package cht_pkg;

  localparam int KEY_W       = 31;
  localparam int NAME_W      = 8;
  localparam int ORDER_W     = 31;
  localparam int BIDX_W      = 5;
  localparam int DIGIT_W     = 8;
  localparam int KEY_DIGITS  = 4;
  localparam int KEY_PAD_W   = DIGIT_W * KEY_DIGITS;
  localparam int REM_W       = KEY_PAD_W - DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(KEY_DIGITS - 1);
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [BIDX_W-1:0]    bucket_index;
    logic [KEY_W-1:0]     key;
    logic [NAME_W-1:0]    name;
    logic [ORDER_W-1:0]   order;
    logic                 last;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/cht_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Small register queue used between the front, the back and the result ports.
module cht_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cht_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Front end: takes input items, hashes insert keys and queues commands.
module cht_front #(
  parameter int  NUM_BUCKETS = 23,
  parameter type cmd_t       = logic
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          hold,
  input  logic                          push,
  output logic                          full,
  input  logic                          op,
  input  logic [cht_pkg::KEY_W-1:0]     key,
  input  logic [cht_pkg::NAME_W-1:0]    name_char,
  input  logic [cht_pkg::ORDER_W-1:0]   order_value,
  input  logic [cht_pkg::BIDX_W-1:0]    bucket_select,
  output cmd_t                          cmd,
  output logic                          cmd_push,
  input  logic                          cmd_full
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int SW = (BW + 1 > cht_pkg::BIDX_W) ? BW + 1 : cht_pkg::BIDX_W;
  localparam logic [BW:0] NB_EXT = (BW + 1)'(NUM_BUCKETS);
  localparam logic [cht_pkg::DIGIT_CNT_W-1:0] HASH_LAST =
      cht_pkg::DIGIT_CNT_W'(cht_pkg::KEY_DIGITS - 2);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_SEND = 3'b100
  } fstate_t;

  fstate_t                              state;
  fstate_t                              state_next;
  cht_pkg::op_t                         op_q;
  logic                                 bad_q;
  logic [cht_pkg::BIDX_W-1:0]           sel_q;
  logic [cht_pkg::KEY_W-1:0]            key_q;
  logic [cht_pkg::NAME_W-1:0]           name_q;
  logic [cht_pkg::ORDER_W-1:0]          order_q;
  logic [BW-1:0]                        rem_acc;
  logic [cht_pkg::REM_W-1:0]            rem_digits;
  logic [cht_pkg::DIGIT_CNT_W-1:0]      dig_cnt;
  logic                                 ready;
  logic                                 accept;
  logic                                 in_read;
  logic [cht_pkg::KEY_PAD_W-1:0]        key_pad;

  // Eight steps of binary long division, keeping only the remainder.
  function automatic logic [BW-1:0] mod_step(input logic [BW-1:0] r_in,
                                             input logic [cht_pkg::DIGIT_W-1:0] d);
    logic [BW:0]   t;
    logic [BW-1:0] r;
    r = r_in;
    for (int i = cht_pkg::DIGIT_W - 1; i >= 0; i--) begin
      t = {r, d[i]};
      if (t >= NB_EXT) begin
        t = t - NB_EXT;
      end
      r = t[BW-1:0];
    end
    return r;
  endfunction

  assign ready   = !hold && ((state == F_IDLE) || ((state == F_SEND) && !cmd_full));
  assign full    = !ready;
  assign accept  = push && ready;
  assign in_read = (cht_pkg::op_t'(op) == cht_pkg::OP_READ);
  assign key_pad = cht_pkg::KEY_PAD_W'(key);

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = in_read ? F_SEND : F_HASH;
        end
      end
      F_HASH: begin
        if (dig_cnt == HASH_LAST) begin
          state_next = F_SEND;
        end
      end
      F_SEND: begin
        if (!cmd_full) begin
          if (accept) begin
            state_next = in_read ? F_SEND : F_HASH;
          end else begin
            state_next = F_IDLE;
          end
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The top digit is reduced as the item is taken, the rest one per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= cht_pkg::op_t'(op);
      bad_q      <= (SW'(bucket_select) >= SW'(NUM_BUCKETS));
      sel_q      <= bucket_select;
      key_q      <= key;
      name_q     <= name_char;
      order_q    <= order_value;
      rem_digits <= key_pad[cht_pkg::REM_W-1:0];
      dig_cnt    <= '0;
      if (in_read) begin
        rem_acc <= BW'(bucket_select);
      end else begin
        rem_acc <= mod_step('0, key_pad[cht_pkg::KEY_PAD_W-1 -: cht_pkg::DIGIT_W]);
      end
    end else if (state == F_HASH) begin
      rem_acc    <= mod_step(rem_acc, rem_digits[cht_pkg::REM_W-1 -: cht_pkg::DIGIT_W]);
      rem_digits <= rem_digits << cht_pkg::DIGIT_W;
      dig_cnt    <= dig_cnt + cht_pkg::DIGIT_CNT_W'(1);
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = op_q;
    cmd.bad_sel = bad_q;
    cmd.bucket  = rem_acc;
    cmd.bidx    = (op_q == cht_pkg::OP_READ) ? sel_q : cht_pkg::BIDX_W'(rem_acc);
    cmd.key     = key_q;
    cmd.name    = name_q;
    cmd.order   = order_q;
  end

  assign cmd_push = (state == F_SEND);

endmodule
`default_nettype wire

// ----- rtl/cht_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Back end: bucket table, node pool, chain appends and chain walks.
module cht_back #(
  parameter int  NUM_BUCKETS = 23,
  parameter int  POOL_DEPTH  = 64,
  parameter type cmd_t       = logic
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output cht_pkg::res_t res,
  output logic          res_push,
  input  logic          res_full,
  output logic          clearing
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int PW = $clog2(POOL_DEPTH);

  typedef struct packed {
    logic          nonempty;
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
  } bkt_t;

  typedef struct packed {
    logic [cht_pkg::KEY_W-1:0]   key;
    logic [cht_pkg::NAME_W-1:0]  name;
    logic [cht_pkg::ORDER_W-1:0] order;
  } node_t;

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_DEC   = 4'b0100,
    B_WALK  = 4'b1000
  } bstate_t;

  bkt_t           bkt_mem  [NUM_BUCKETS];
  node_t          node_mem [POOL_DEPTH];
  logic [PW-1:0]  link_mem [POOL_DEPTH];

  bstate_t        state;
  bstate_t        state_next;
  logic [BW-1:0]  clr_idx;
  logic [PW:0]    nodes_used;
  cmd_t           c;
  bkt_t           bkt_rd;
  node_t          node_rd;
  logic [PW-1:0]  link_rd;
  logic [PW-1:0]  cur;
  logic [PW-1:0]  tail;
  logic [PW-1:0]  walk_cnt;
  logic           pool_full;
  logic [PW-1:0]  new_idx;
  logic           walk_fin;
  logic           bkt_we;
  logic [BW-1:0]  bkt_wa;
  bkt_t           bkt_wd;
  logic           node_we;
  logic           link_we;
  logic           node_re;
  logic [PW-1:0]  node_ra;

  assign pool_full = (nodes_used == (PW + 1)'(POOL_DEPTH));
  assign new_idx   = nodes_used[PW-1:0];
  assign walk_fin  = (cur == tail) || (walk_cnt == PW'(POOL_DEPTH - 1));
  assign cmd_pop   = (state == B_IDLE) && !cmd_empty;
  assign clearing  = (state == B_CLEAR);

  always_comb begin
    state_next       = state;
    res              = '0;
    res.bucket_index = c.bidx;
    res_push         = 1'b0;
    bkt_we           = 1'b0;
    bkt_wa           = c.bucket;
    bkt_wd           = '0;
    node_we          = 1'b0;
    link_we          = 1'b0;
    node_re          = 1'b0;
    node_ra          = bkt_rd.head;
    case (state)
      B_CLEAR: begin
        bkt_we = 1'b1;
        bkt_wa = clr_idx;
        if (clr_idx == BW'(NUM_BUCKETS - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!cmd_empty) begin
          state_next = B_DEC;
        end
      end
      B_DEC: begin
        if (c.op == cht_pkg::OP_INSERT) begin
          res.status = pool_full ? cht_pkg::ST_FULL : cht_pkg::ST_OK;
          res.key    = c.key;
          res.name   = c.name;
          res.order  = c.order;
          res.last   = 1'b1;
          if (!res_full) begin
            res_push   = 1'b1;
            state_next = B_IDLE;
            if (!pool_full) begin
              // Append at the tail: an empty bucket also gets its head set.
              bkt_we          = 1'b1;
              bkt_wd.nonempty = 1'b1;
              bkt_wd.head     = bkt_rd.nonempty ? bkt_rd.head : new_idx;
              bkt_wd.tail     = new_idx;
              node_we         = 1'b1;
              link_we         = bkt_rd.nonempty;
            end
          end
        end else if (c.bad_sel || !bkt_rd.nonempty) begin
          res.status = cht_pkg::ST_EMPTY;
          res.last   = 1'b1;
          if (!res_full) begin
            res_push   = 1'b1;
            state_next = B_IDLE;
          end
        end else begin
          node_re    = 1'b1;
          state_next = B_WALK;
        end
      end
      B_WALK: begin
        res.status = cht_pkg::ST_OK;
        res.key    = node_rd.key;
        res.name   = node_rd.name;
        res.order  = node_rd.order;
        res.last   = walk_fin;
        node_ra    = link_rd;
        if (!res_full) begin
          res_push = 1'b1;
          if (walk_fin) begin
            state_next = B_IDLE;
          end else begin
            node_re = 1'b1;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clr_idx    <= '0;
      nodes_used <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_idx <= clr_idx + BW'(1);
      end
      if (node_we) begin
        nodes_used <= nodes_used + (PW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      c <= cmd;
    end
    if (state == B_DEC) begin
      tail     <= bkt_rd.tail;
      walk_cnt <= '0;
    end else if ((state == B_WALK) && res_push) begin
      walk_cnt <= walk_cnt + PW'(1);
    end
    if (node_re) begin
      cur <= node_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_wa] <= bkt_wd;
    end
    if (cmd_pop) begin
      bkt_rd <= bkt_mem[cmd.bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[new_idx] <= '{key: c.key, name: c.name, order: c.order};
    end
    if (node_re) begin
      node_rd <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[bkt_rd.tail] <= new_idx;
    end
    if (node_re) begin
      link_rd <= link_mem[node_ra];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/chained_hash_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the chained hash table.
//
//   Channel   Direction  Handshake    Contents
//   items     in         push / full  op, key, name_char, order_value, bucket_select
//   results   out        pop / empty  status, bucket_index, out_key, out_name,
//                                     out_order, last
//
// The front reduces an insert's key modulo NUM_BUCKETS one 8-bit digit per cycle, the
// top digit as the item is taken, and takes no new item until it hands the command on.
// The back works on one command at a time; an insert or an empty read gives one
// result, and a walk gives its records one per cycle while the result queue has room.
// After reset the bucket table is cleared with full held high.
// Results wait in a two-entry queue; a stalled consumer holds the back end once it fills.
module chained_hash_table #(
  parameter int NUM_BUCKETS = 23,
  parameter int POOL_DEPTH  = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          op,
  input  logic [cht_pkg::KEY_W-1:0]     key,
  input  logic [cht_pkg::NAME_W-1:0]    name_char,
  input  logic [cht_pkg::ORDER_W-1:0]   order_value,
  input  logic [cht_pkg::BIDX_W-1:0]    bucket_select,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    status,
  output logic [cht_pkg::BIDX_W-1:0]    bucket_index,
  output logic [cht_pkg::KEY_W-1:0]     out_key,
  output logic [cht_pkg::NAME_W-1:0]    out_name,
  output logic [cht_pkg::ORDER_W-1:0]   out_order,
  output logic                          last
);

  localparam int BW = $clog2(NUM_BUCKETS);

  typedef struct packed {
    cht_pkg::op_t                 op;
    logic                         bad_sel;
    logic [BW-1:0]                bucket;
    logic [cht_pkg::BIDX_W-1:0]   bidx;
    logic [cht_pkg::KEY_W-1:0]    key;
    logic [cht_pkg::NAME_W-1:0]   name;
    logic [cht_pkg::ORDER_W-1:0]  order;
  } cmd_t;

  cmd_t           front_cmd;
  logic           front_push;
  cmd_t           back_cmd;
  logic           cmd_full;
  logic           cmd_empty;
  logic           cmd_pop;
  cht_pkg::res_t  back_res;
  logic           res_push;
  logic           res_full;
  cht_pkg::res_t  res_head;
  logic           clearing;

  cht_front #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .cmd_t       (cmd_t)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .hold          (clearing),
    .push          (push),
    .full          (full),
    .op            (op),
    .key           (key),
    .name_char     (name_char),
    .order_value   (order_value),
    .bucket_select (bucket_select),
    .cmd           (front_cmd),
    .cmd_push      (front_push),
    .cmd_full      (cmd_full)
  );

  cht_fifo #(
    .DEPTH (cht_pkg::QUEUE_DEPTH),
    .T     (cmd_t)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  cht_back #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .POOL_DEPTH  (POOL_DEPTH),
    .cmd_t       (cmd_t)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full),
    .clearing  (clearing)
  );

  cht_fifo #(
    .DEPTH (cht_pkg::QUEUE_DEPTH),
    .T     (cht_pkg::res_t)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign status       = res_head.status;
  assign bucket_index = res_head.bucket_index;
  assign out_key      = res_head.key;
  assign out_name     = res_head.name;
  assign out_order    = res_head.order;
  assign last         = res_head.last;

endmodule
`default_nettype wire

// ----- rtl/cht_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the chained hash table, bound to its top level.
module cht_port_checks (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          full,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [1:0]                    status,
  input  logic [cht_pkg::KEY_W-1:0]     out_key,
  input  logic [cht_pkg::ORDER_W-1:0]   out_order,
  input  logic                          last
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // The bucket table is being cleared just after reset, so no item may enter.
  a_reset_full: assert property (@(posedge clk) rst |=> full)
    else $error("input taken during the clearing pass");

  // A dropped insert or an empty read gives exactly one result.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
      (!empty && (status == cht_pkg::ST_FULL || status == cht_pkg::ST_EMPTY)) |-> last)
    else $error("non-ok result not marked as the last one");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (status == cht_pkg::ST_OK || status == cht_pkg::ST_FULL ||
                  status == cht_pkg::ST_EMPTY))
    else $error("undefined status code on a waiting result");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(status) && $stable(out_key) &&
                            $stable(out_order) && $stable(last)))
    else $error("waiting result changed before its transfer");

endmodule

bind chained_hash_table cht_port_checks u_cht_port_checks (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .status    (status),
  .out_key   (out_key),
  .out_order (out_order),
  .last      (last)
);
`default_nettype wire

// ----- sim/cht_checker.sv -----
`timescale 1ns / 1ps
// Checker for the chained hash table: mirrors the table and compares every result.
module cht_checker
  import cht_pkg::*;
#(
  parameter int NUM_BUCKETS = 23,
  parameter int POOL_DEPTH  = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  logic                 op,
  input  logic [KEY_W-1:0]     key,
  input  logic [NAME_W-1:0]    name_char,
  input  logic [ORDER_W-1:0]   order_value,
  input  logic [BIDX_W-1:0]    bucket_select,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [1:0]           status,
  input  logic [BIDX_W-1:0]    bucket_index,
  input  logic [KEY_W-1:0]     out_key,
  input  logic [NAME_W-1:0]    out_name,
  input  logic [ORDER_W-1:0]   out_order,
  input  logic                 last,
  output int                   fail_count,
  output int                   pending,
  output int                   results_checked,
  output int                   dropped_inserts,
  output int                   empty_reads,
  output int                   longest_walk
);

  localparam int NODE_W = $clog2(POOL_DEPTH);

  // Shadow copy of the bucket table and the node pool.
  bit                 chain_live [NUM_BUCKETS];
  logic [NODE_W-1:0]  chain_head [NUM_BUCKETS];
  logic [NODE_W-1:0]  chain_tail [NUM_BUCKETS];
  logic [NODE_W-1:0]  next_node  [POOL_DEPTH];
  logic [KEY_W-1:0]   rec_key    [POOL_DEPTH];
  logic [NAME_W-1:0]  rec_name   [POOL_DEPTH];
  logic [ORDER_W-1:0] rec_order  [POOL_DEPTH];
  int                 nodes_taken;

  res_t awaited_results[$];
  res_t seen;
  res_t want;

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    dropped_inserts = 0;
    empty_reads     = 0;
    longest_walk    = 0;
    nodes_taken     = 0;
  end

  // Works out the results of one accepted item and updates the shadow table.
  task automatic apply_table_op(input op_t o, input logic [KEY_W-1:0] k,
                                input logic [NAME_W-1:0] nm, input logic [ORDER_W-1:0] ord,
                                input logic [BIDX_W-1:0] sel);
    res_t              rec;
    int                b;
    int                n_out;
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] slot;
    bit                fin;
    if (o == OP_INSERT) begin
      b                = int'(k) % NUM_BUCKETS;
      rec.bucket_index = b[BIDX_W-1:0];
      rec.key          = k;
      rec.name         = nm;
      rec.order        = ord;
      rec.last         = 1'b1;
      if (nodes_taken >= POOL_DEPTH) begin
        rec.status = ST_FULL;
        dropped_inserts++;
      end else begin
        rec.status      = ST_OK;
        slot            = nodes_taken[NODE_W-1:0];
        rec_key[slot]   = k;
        rec_name[slot]  = nm;
        rec_order[slot] = ord;
        next_node[slot] = '0;
        if (chain_live[b]) begin
          next_node[chain_tail[b]] = slot;
        end else begin
          chain_head[b] = slot;
          chain_live[b] = 1'b1;
        end
        chain_tail[b] = slot;
        nodes_taken++;
      end
      awaited_results.push_back(rec);
    end else if (sel >= NUM_BUCKETS || !chain_live[sel]) begin
      // Unknown buckets read back exactly like empty ones.
      rec.status       = ST_EMPTY;
      rec.bucket_index = sel;
      rec.key          = '0;
      rec.name         = '0;
      rec.order        = '0;
      rec.last         = 1'b1;
      awaited_results.push_back(rec);
      empty_reads++;
    end else begin
      cur   = chain_head[sel];
      n_out = 0;
      do begin
        fin              = (cur == chain_tail[sel]) || (n_out + 1 >= POOL_DEPTH);
        rec.status       = ST_OK;
        rec.bucket_index = sel;
        rec.key          = rec_key[cur];
        rec.name         = rec_name[cur];
        rec.order        = rec_order[cur];
        rec.last         = fin;
        awaited_results.push_back(rec);
        n_out++;
        cur = next_node[cur];
      end while (!fin);
      if (n_out > longest_walk) longest_walk = n_out;
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      nodes_taken = 0;
      foreach (chain_live[i]) chain_live[i] = 1'b0;
      awaited_results.delete();
    end else begin
      if (push && !full) begin
        apply_table_op(op_t'(op), key, name_char, order_value, bucket_select);
      end
      if (pop && !empty) begin
        seen.status       = status_t'(status);
        seen.bucket_index = bucket_index;
        seen.key          = out_key;
        seen.name         = out_name;
        seen.order        = out_order;
        seen.last         = last;
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing awaited: status %0d, bucket %0d, key %0d",
                 status, bucket_index, out_key);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, seen.status);
          check_field("bucket_index", want.bucket_index, seen.bucket_index);
          check_field("out_key", want.key, seen.key);
          check_field("out_name", want.name, seen.name);
          check_field("out_order", want.order, seen.order);
          check_field("last", want.last, seen.last);
        end
        results_checked++;
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ----- sim/tb_chained_hash_table.sv -----
`timescale 1ns / 1ps
// Testbench top for the chained hash table: stimulus, flow control and verdict.
module tb_chained_hash_table;
  import cht_pkg::*;

  localparam int NUM_BUCKETS  = 23;
  localparam int POOL_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 365;
  localparam int CALM_ITEMS   = 60;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 30;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic                 op;
  logic [KEY_W-1:0]     key;
  logic [NAME_W-1:0]    name_char;
  logic [ORDER_W-1:0]   order_value;
  logic [BIDX_W-1:0]    bucket_select;
  logic                 empty;
  logic                 pop;
  logic [1:0]           status;
  logic [BIDX_W-1:0]    bucket_index;
  logic [KEY_W-1:0]     out_key;
  logic [NAME_W-1:0]    out_name;
  logic [ORDER_W-1:0]   out_order;
  logic                 last;

  int fail_count;
  int pending;
  int results_checked;
  int dropped_inserts;
  int empty_reads;
  int longest_walk;

  bit calm;
  bit hold_request;
  int stall_left;
  int quiet_cycles;
  int inserts_sent;
  int reads_sent;
  int hot_bucket;

  always #5 clk = ~clk;

  chained_hash_table #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .POOL_DEPTH (POOL_DEPTH)
  ) dut (.*);

  cht_checker #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .POOL_DEPTH (POOL_DEPTH)
  ) checker_i (.*);

  // Offers one item and returns once its transfer has taken place.
  task automatic send_item(input op_t o, input logic [KEY_W-1:0] k,
                           input logic [NAME_W-1:0] nm, input logic [ORDER_W-1:0] ord,
                           input logic [BIDX_W-1:0] sel);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    op            <= o;
    key           <= k;
    name_char     <= nm;
    order_value   <= ord;
    bucket_select <= sel;
    push          <= 1'b1;
    do @(posedge clk); while (full);
    if (o == OP_INSERT) inserts_sent++;
    else reads_sent++;
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    pop        = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("No transfer for %0d cycles, %0d results still awaited", quiet_cycles, pending);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0]   k;
    logic [BIDX_W-1:0]  sel;
    int                 pick;
    int                 insert_pct;
    rst           = 1'b1;
    push          = 1'b0;
    op            = OP_INSERT;
    key           = '0;
    name_char     = '0;
    order_value   = '0;
    bucket_select = '0;
    calm          = 1'b0;
    hold_request  = 1'b0;
    quiet_cycles  = 0;
    inserts_sent  = 0;
    reads_sent    = 0;
    hot_bucket    = $urandom_range(0, NUM_BUCKETS - 1);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reads of empty and out-of-range buckets before anything is stored.
    send_item(OP_READ, '0, '0, '0, 5'd0);
    send_item(OP_READ, '0, '0, '0, 5'd22);
    send_item(OP_READ, '0, '0, '0, 5'd23);
    send_item(OP_READ, '1, '1, '1, 5'd31);
    // Extremes of the record fields; keys 0, 23 and 46 share bucket 0.
    send_item(OP_INSERT, '0, '0, '0, 5'd31);
    send_item(OP_INSERT, 31'h7FFF_FFFF, 8'hFF, 31'h7FFF_FFFF, 5'd0);
    send_item(OP_INSERT, 31'd22, 8'h55, 31'h2AAA_AAAA, 5'd0);
    send_item(OP_INSERT, 31'd23, 8'hAA, 31'h5555_5555, 5'd0);
    send_item(OP_INSERT, 31'd46, 8'h01, 31'd1, 5'd0);
    send_item(OP_READ, '0, '0, '0, 5'd0);
    send_item(OP_READ, '0, '0, '0, 5'd22);
    send_item(OP_READ, '0, '0, '0, 5'd5);
    send_item(OP_READ, '0, '0, '0, 5'd1);
    // The largest key that still lands in bucket 0 extends that chain again.
    send_item(OP_INSERT, 31'd2147483642, 8'h80, 31'h4000_0000, 5'd0);
    send_item(OP_READ, '0, '0, '0, 5'd0);

    // Early on mostly inserts so the pool fills and one bucket grows a long chain;
    // later mostly reads, with inserts that meet a full pool.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (i == HOLD_AT) hold_request = 1'b1;
      insert_pct = (i < 110) ? 60 : 25;
      pick       = $urandom_range(0, 99);
      if (pick < insert_pct) begin
        if ($urandom_range(0, 9) < 6) begin
          k = KEY_W'(NUM_BUCKETS * $urandom_range(0, 93368000) + hot_bucket);
        end else begin
          k = KEY_W'($urandom());
        end
        send_item(OP_INSERT, k, NAME_W'($urandom()), ORDER_W'($urandom()),
                  BIDX_W'($urandom()));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 4) sel = BIDX_W'(hot_bucket);
        else if (pick < 8) sel = BIDX_W'($urandom_range(0, NUM_BUCKETS - 1));
        else sel = BIDX_W'($urandom_range(NUM_BUCKETS, 31));
        send_item(OP_READ, KEY_W'($urandom()), NAME_W'($urandom()),
                  ORDER_W'($urandom()), sel);
      end
    end
    @(negedge clk);
    push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d inserts (%0d refused on a full pool) and %0d reads (%0d empty).",
             inserts_sent, dropped_inserts, reads_sent, empty_reads);
    $display("Checked %0d results; longest chain walked was %0d records.",
             results_checked, longest_walk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
